FILE: hw/rtl/sch_pkg.sv
package sch_pkg;

	typedef enum logic [3:0] {
		PH_IDLE        = 4'd0,
		PH_WAIT_METHOD = 4'd1,
		PH_SEND_USER   = 4'd2,
		PH_SEND_PASS   = 4'd3,
		PH_WAIT_AUTH   = 4'd4,
		PH_SEND_ADDR   = 4'd5,
		PH_WAIT_REPLY  = 4'd6,
		PH_OK          = 4'd7,
		PH_FAILED      = 4'd8
	} phase_t;

	localparam logic [2:0] OP_START = 3'd0;
	localparam logic [2:0] OP_RX    = 3'd1;
	localparam logic [2:0] OP_TICK  = 3'd2;
	localparam logic [2:0] OP_HOST  = 3'd3;
	localparam logic [2:0] OP_LINK  = 3'd4;

	localparam logic [2:0] FAIL_NONE      = 3'd0;
	localparam logic [2:0] FAIL_TIMEOUT   = 3'd1;
	localparam logic [2:0] FAIL_LINK      = 3'd2;
	localparam logic [2:0] FAIL_METHOD    = 3'd3;
	localparam logic [2:0] FAIL_AUTH      = 3'd4;
	localparam logic [2:0] FAIL_BAD_REPLY = 3'd5;
	localparam logic [2:0] FAIL_REFUSED   = 3'd6;

	localparam int          CFG_IDX_W       = 2;
	localparam logic [1:0]  CFG_USE_AUTH    = 2'd0;
	localparam logic [1:0]  CFG_USER_LEN    = 2'd1;
	localparam logic [1:0]  CFG_PASS_LEN    = 2'd2;
	localparam logic [1:0]  CFG_TIMEOUT     = 2'd3;
	localparam logic [15:0] TIMEOUT_RST     = 16'd10000;

	localparam logic [7:0] SOCKS_VER      = 8'h05;
	localparam logic [7:0] METH_NONE      = 8'h00;
	localparam logic [7:0] METH_USERPASS  = 8'h02;
	localparam logic [7:0] METH_REJECT    = 8'hFF;
	localparam logic [7:0] AUTH_VER       = 8'h01;
	localparam logic [7:0] REQ_CONNECT    = 8'h01;
	localparam logic [7:0] RSV_BYTE       = 8'h00;
	localparam logic [7:0] ADDR_TYPE_V4   = 8'h01;
	localparam logic [7:0] ADDR_TYPE_NAME = 8'h03;
	localparam logic [7:0] ADDR_TYPE_V6   = 8'h04;

	localparam int BURST_MAX = 8;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [7:0]  byte_value;
		logic        dest_is_domain;
		logic [15:0] dest_port;
		logic [7:0]  addr_len;
	} item_t;

	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic [3:0]  phase;
		logic        done_res;
		logic        success;
		logic [2:0]  err_kind;
		logic [7:0]  rep_code;
		logic        last;
	} result_t;

	typedef struct packed {
		logic        use_auth;
		logic [7:0]  user_len;
		logic [7:0]  pass_len;
		logic [15:0] timeout_ticks;
	} cfg_t;

	// bytes to send for one item plus the status shared by all its beats
	typedef struct packed {
		logic [BURST_MAX-1:0][7:0] bytes;
		logic [3:0]                cnt;
		logic [3:0]                phase;
		logic                      done_res;
		logic                      success;
		logic [2:0]                err_kind;
		logic [7:0]                rep_code;
	} burst_t;

endpackage

FILE: hw/rtl/socks5_client_handshake.sv
// Client side of a SOCKS5 handshake with optional username/password login.
// Each accepted item (start, received byte, tick, host byte, link lost) is
// evaluated combinationally against the handshake state, and the bytes it causes
// to be sent are captured in a burst register that is played out as one beat
// per byte, or a single status beat when nothing is sent; every beat carries
// the phase and, for the item that ends the handshake, its outcome.
// An item whose burst is n beats long (1 to 7) holds the result side until
// its n beats have left; the next item is taken in the cycle the last beat of
// the previous one leaves, so single-beat items flow at one per cycle while
// result_stall is low. The burst register and result_stall pace the block.
// Configuration writes must be made while no beats are pending.
module socks5_client_handshake (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  sch_pkg::item_t                    item,
	output logic                              result_valid,
	input  logic                              result_stall,
	output sch_pkg::result_t                  result,
	input  logic                              wr_en,
	input  logic [sch_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [15:0]                       wr_data
);

	sch_pkg::cfg_t   cfg_q;
	sch_pkg::burst_t burst_next;
	sch_pkg::burst_t burst_q;
	logic            busy_q;
	logic [2:0]      pos_q;
	logic            accept;
	logic            drain;
	logic            beat_last;
	logic [2:0]      last_pos;

	sch_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.cfg    (cfg_q),
		.burst  (burst_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.use_auth      <= 1'b0;
			cfg_q.user_len      <= 8'd0;
			cfg_q.pass_len      <= 8'd0;
			cfg_q.timeout_ticks <= sch_pkg::TIMEOUT_RST;
		end else if (wr_en) begin
			case (wr_index)
				sch_pkg::CFG_USE_AUTH: cfg_q.use_auth      <= wr_data[0];
				sch_pkg::CFG_USER_LEN: cfg_q.user_len      <= wr_data[7:0];
				sch_pkg::CFG_PASS_LEN: cfg_q.pass_len      <= wr_data[7:0];
				sch_pkg::CFG_TIMEOUT:  cfg_q.timeout_ticks <= wr_data;
				default: ;
			endcase
		end
	end

	// a burst with no bytes still yields one status beat
	assign last_pos   = (burst_q.cnt == 4'd0) ? 3'd0 : 3'(burst_q.cnt - 4'd1);
	assign beat_last  = (pos_q == last_pos);
	assign drain      = busy_q && !result_stall;
	assign item_stall = busy_q && !(drain && beat_last);
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= 3'd0;
		end else if (accept) begin
			busy_q <= 1'b1;
			pos_q  <= 3'd0;
		end else if (drain) begin
			if (beat_last) begin
				busy_q <= 1'b0;
			end else begin
				pos_q <= pos_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			burst_q <= burst_next;
		end
	end

	assign result_valid = busy_q;

	always_comb begin
		result.tx_valid = (burst_q.cnt != 4'd0);
		result.tx_byte  = (burst_q.cnt != 4'd0) ? burst_q.bytes[pos_q] : 8'd0;
		result.phase    = burst_q.phase;
		result.done_res = burst_q.done_res;
		result.success  = burst_q.success;
		result.err_kind = burst_q.err_kind;
		result.rep_code = burst_q.rep_code;
		result.last     = beat_last;
	end

endmodule

FILE: hw/rtl/sch_engine.sv
module sch_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  sch_pkg::item_t item,
	input  sch_pkg::cfg_t  cfg,
	output sch_pkg::burst_t burst
);

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_GREET,
		ACT_AUTH_REQ,
		ACT_CONNECT,
		ACT_USER_BYTE,
		ACT_PASS_BYTE,
		ACT_ADDR_BYTE
	} act_t;

	sch_pkg::phase_t phase_q, phase_n;
	logic [7:0]  idx_q, idx_n;
	logic [7:0]  skip_q, skip_n;
	logic [15:0] timer_q, timer_n;
	logic        dom_q, dom_n;
	logic [15:0] port_q, port_n;
	logic [7:0]  tlen_q, tlen_n;
	logic [7:0]  first_q, first_n;
	logic [7:0]  rep_q, rep_n;

	act_t        act;
	logic        end_done, end_ok;
	logic [2:0]  end_err;
	logic [7:0]  end_rep;
	logic [7:0]  idx_inc;
	logic [7:0]  b;
	logic        waiting;

	assign idx_inc = idx_q + 8'd1;
	assign b       = item.byte_value;
	assign waiting = phase_q inside {sch_pkg::PH_WAIT_METHOD, sch_pkg::PH_WAIT_AUTH,
	                                 sch_pkg::PH_WAIT_REPLY};

	// next state
	always_comb begin
		phase_n  = phase_q;
		idx_n    = idx_q;
		skip_n   = skip_q;
		timer_n  = timer_q;
		dom_n    = dom_q;
		port_n   = port_q;
		tlen_n   = tlen_q;
		first_n  = first_q;
		rep_n    = rep_q;
		act      = ACT_NONE;
		end_done = 1'b0;
		end_ok   = 1'b0;
		end_err  = sch_pkg::FAIL_NONE;
		end_rep  = 8'd0;

		case (item.opcode)
			sch_pkg::OP_START: begin
				dom_n   = item.dest_is_domain;
				port_n  = item.dest_port;
				tlen_n  = item.dest_is_domain ? item.addr_len : 8'd4;
				act     = ACT_GREET;
				phase_n = sch_pkg::PH_WAIT_METHOD;
				idx_n   = 8'd0;
				skip_n  = 8'd0;
				timer_n = cfg.timeout_ticks;
			end
			sch_pkg::OP_RX: begin
				case (phase_q)
					sch_pkg::PH_WAIT_METHOD: begin
						if (idx_q == 8'd0) begin
							first_n = b;
							idx_n   = 8'd1;
						end else if (first_q != sch_pkg::SOCKS_VER ||
						             b == sch_pkg::METH_REJECT) begin
							phase_n  = sch_pkg::PH_FAILED;
							end_done = 1'b1;
							end_err  = sch_pkg::FAIL_METHOD;
						end else if (b == sch_pkg::METH_USERPASS) begin
							if (!cfg.use_auth) begin
								phase_n  = sch_pkg::PH_FAILED;
								end_done = 1'b1;
								end_err  = sch_pkg::FAIL_AUTH;
							end else begin
								act = ACT_AUTH_REQ;
								if (cfg.user_len != 8'd0) begin
									phase_n = sch_pkg::PH_SEND_USER;
									idx_n   = 8'd0;
								end else if (cfg.pass_len != 8'd0) begin
									phase_n = sch_pkg::PH_SEND_PASS;
									idx_n   = 8'd0;
								end else begin
									phase_n = sch_pkg::PH_WAIT_AUTH;
									idx_n   = 8'd0;
									skip_n  = 8'd0;
									timer_n = cfg.timeout_ticks;
								end
							end
						end else if (b != sch_pkg::METH_NONE) begin
							phase_n  = sch_pkg::PH_FAILED;
							end_done = 1'b1;
							end_err  = sch_pkg::FAIL_METHOD;
						end else begin
							act = ACT_CONNECT;
							if (tlen_q == 8'd0) begin
								phase_n = sch_pkg::PH_WAIT_REPLY;
								skip_n  = 8'd0;
								timer_n = cfg.timeout_ticks;
							end else begin
								phase_n = sch_pkg::PH_SEND_ADDR;
							end
							idx_n = 8'd0;
						end
					end
					sch_pkg::PH_WAIT_AUTH: begin
						if (idx_q == 8'd0) begin
							idx_n = 8'd1;
						end else if (b != 8'd0) begin
							phase_n  = sch_pkg::PH_FAILED;
							end_done = 1'b1;
							end_err  = sch_pkg::FAIL_AUTH;
						end else begin
							act = ACT_CONNECT;
							if (tlen_q == 8'd0) begin
								phase_n = sch_pkg::PH_WAIT_REPLY;
								skip_n  = 8'd0;
								timer_n = cfg.timeout_ticks;
							end else begin
								phase_n = sch_pkg::PH_SEND_ADDR;
							end
							idx_n = 8'd0;
						end
					end
					sch_pkg::PH_WAIT_REPLY: begin
						case (idx_q)
							8'd0: begin
								first_n = b;
								idx_n   = 8'd1;
							end
							8'd1: begin
								rep_n = b;
								idx_n = 8'd2;
							end
							8'd2: idx_n = 8'd3;
							8'd3: begin
								if (first_q != sch_pkg::SOCKS_VER) begin
									phase_n  = sch_pkg::PH_FAILED;
									end_done = 1'b1;
									end_err  = sch_pkg::FAIL_BAD_REPLY;
								end else if (rep_q != 8'd0) begin
									phase_n  = sch_pkg::PH_FAILED;
									end_done = 1'b1;
									end_err  = sch_pkg::FAIL_REFUSED;
									end_rep  = rep_q;
								end else if (b == sch_pkg::ADDR_TYPE_V4) begin
									skip_n = 8'd4;
									idx_n  = 8'd5;
								end else if (b == sch_pkg::ADDR_TYPE_V6) begin
									skip_n = 8'd16;
									idx_n  = 8'd5;
								end else if (b == sch_pkg::ADDR_TYPE_NAME) begin
									idx_n = 8'd4;
								end else begin
									phase_n  = sch_pkg::PH_FAILED;
									end_done = 1'b1;
									end_err  = sch_pkg::FAIL_BAD_REPLY;
								end
							end
							8'd4: begin
								// domain length byte; empty name goes straight to the port
								if (b == 8'd0) begin
									skip_n = 8'd2;
									idx_n  = 8'd6;
								end else begin
									skip_n = b;
									idx_n  = 8'd5;
								end
							end
							8'd5: begin
								skip_n = skip_q - 8'd1;
								if (skip_q == 8'd1) begin
									skip_n = 8'd2;
									idx_n  = 8'd6;
								end
							end
							default: begin
								skip_n = skip_q - 8'd1;
								if (skip_q == 8'd1) begin
									phase_n  = sch_pkg::PH_OK;
									end_done = 1'b1;
									end_ok   = 1'b1;
								end
							end
						endcase
					end
					default: ;
				endcase
			end
			sch_pkg::OP_TICK: begin
				if (waiting) begin
					if (timer_q <= 16'd1) begin
						timer_n  = 16'd0;
						phase_n  = sch_pkg::PH_FAILED;
						end_done = 1'b1;
						end_err  = sch_pkg::FAIL_TIMEOUT;
					end else begin
						timer_n = timer_q - 16'd1;
					end
				end
			end
			sch_pkg::OP_HOST: begin
				case (phase_q)
					sch_pkg::PH_SEND_USER: begin
						act   = ACT_USER_BYTE;
						idx_n = idx_inc;
						if (idx_inc >= cfg.user_len) begin
							idx_n = 8'd0;
							if (cfg.pass_len != 8'd0) begin
								phase_n = sch_pkg::PH_SEND_PASS;
							end else begin
								phase_n = sch_pkg::PH_WAIT_AUTH;
								skip_n  = 8'd0;
								timer_n = cfg.timeout_ticks;
							end
						end
					end
					sch_pkg::PH_SEND_PASS: begin
						act   = ACT_PASS_BYTE;
						idx_n = idx_inc;
						if (idx_inc >= cfg.pass_len) begin
							phase_n = sch_pkg::PH_WAIT_AUTH;
							idx_n   = 8'd0;
							skip_n  = 8'd0;
							timer_n = cfg.timeout_ticks;
						end
					end
					sch_pkg::PH_SEND_ADDR: begin
						act   = ACT_ADDR_BYTE;
						idx_n = idx_inc;
						if (idx_inc >= tlen_q) begin
							phase_n = sch_pkg::PH_WAIT_REPLY;
							idx_n   = 8'd0;
							skip_n  = 8'd0;
							timer_n = cfg.timeout_ticks;
						end
					end
					default: ;
				endcase
			end
			sch_pkg::OP_LINK: begin
				if (phase_q inside {[sch_pkg::PH_WAIT_METHOD:sch_pkg::PH_WAIT_REPLY]}) begin
					phase_n  = sch_pkg::PH_FAILED;
					end_done = 1'b1;
					end_err  = sch_pkg::FAIL_LINK;
				end
			end
			default: ;
		endcase
	end

	// bytes to send
	always_comb begin
		logic [3:0] k;
		k = 4'd0;
		burst.bytes = '0;
		case (act)
			ACT_GREET: begin
				burst.bytes[0] = sch_pkg::SOCKS_VER;
				if (cfg.use_auth) begin
					burst.bytes[1] = 8'h02;
					burst.bytes[2] = sch_pkg::METH_NONE;
					burst.bytes[3] = sch_pkg::METH_USERPASS;
					k = 4'd4;
				end else begin
					burst.bytes[1] = 8'h01;
					burst.bytes[2] = sch_pkg::METH_NONE;
					k = 4'd3;
				end
			end
			ACT_AUTH_REQ: begin
				burst.bytes[0] = sch_pkg::AUTH_VER;
				burst.bytes[1] = cfg.user_len;
				k = 4'd2;
				if (cfg.user_len == 8'd0) begin
					burst.bytes[2] = cfg.pass_len;
					k = 4'd3;
				end
			end
			ACT_CONNECT: begin
				burst.bytes[0] = sch_pkg::SOCKS_VER;
				burst.bytes[1] = sch_pkg::REQ_CONNECT;
				burst.bytes[2] = sch_pkg::RSV_BYTE;
				burst.bytes[3] = dom_q ? sch_pkg::ADDR_TYPE_NAME : sch_pkg::ADDR_TYPE_V4;
				k = 4'd4;
				if (dom_q) begin
					burst.bytes[4] = tlen_q;
					k = 4'd5;
				end
				if (tlen_q == 8'd0) begin
					burst.bytes[k[2:0]] = port_q[15:8];
					burst.bytes[k[2:0] + 3'd1] = port_q[7:0];
					k = k + 4'd2;
				end
			end
			ACT_USER_BYTE: begin
				burst.bytes[0] = b;
				k = 4'd1;
				if (idx_inc >= cfg.user_len) begin
					burst.bytes[1] = cfg.pass_len;
					k = 4'd2;
				end
			end
			ACT_PASS_BYTE: begin
				burst.bytes[0] = b;
				k = 4'd1;
			end
			ACT_ADDR_BYTE: begin
				burst.bytes[0] = b;
				k = 4'd1;
				if (idx_inc >= tlen_q) begin
					burst.bytes[1] = port_q[15:8];
					burst.bytes[2] = port_q[7:0];
					k = 4'd3;
				end
			end
			default: ;
		endcase
		burst.cnt      = k;
		burst.phase    = phase_n;
		burst.done_res = end_done;
		burst.success  = end_ok;
		burst.err_kind = end_err;
		burst.rep_code = end_rep;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sch_pkg::PH_IDLE;
			idx_q   <= 8'd0;
			skip_q  <= 8'd0;
			timer_q <= 16'd0;
			dom_q   <= 1'b0;
			port_q  <= 16'd0;
			tlen_q  <= 8'd0;
			first_q <= 8'd0;
			rep_q   <= 8'd0;
		end else if (accept) begin
			phase_q <= phase_n;
			idx_q   <= idx_n;
			skip_q  <= skip_n;
			timer_q <= timer_n;
			dom_q   <= dom_n;
			port_q  <= port_n;
			tlen_q  <= tlen_n;
			first_q <= first_n;
			rep_q   <= rep_n;
		end
	end

endmodule
